// ===== hdl/gnss_early_prompt_late_correlator_assert.svh =====
// Assertion helpers for the correlator top module.
// Every check is sampled on the rising clock edge and is held off while reset is low.
`ifndef GNSS_EARLY_PROMPT_LATE_CORRELATOR_ASSERT_SVH
`define GNSS_EARLY_PROMPT_LATE_CORRELATOR_ASSERT_SVH

// A condition that must hold on every clock edge out of reset.
`define GEPL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold on the same edge as its trigger.
`define GEPL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gepl_pkg.sv =====
package gepl_pkg;

    // Defaults for the top-level parameters.
    localparam int CODE_DEPTH_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 8;
    localparam int ACC_BITS_DEF    = 32;

    // Code phase format: integer chips above FRAC_CODE fractional bits.
    localparam int FRAC_CODE      = 22;
    localparam int LEN_W          = 11;
    localparam int PH_W           = LEN_W + FRAC_CODE;
    localparam int REM_DIVIDEND_W = 32 - FRAC_CODE;
    localparam int CHIP_IDX_W     = 10;
    localparam int CNT_W          = 17;
    localparam int TIX_W          = 4;
    localparam int TAB_W          = 6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int HALF_W     = 23;

    localparam int N_SUMS    = 6;
    localparam int OUT_W     = 32;
    localparam int RES_W     = N_SUMS * OUT_W;

    // Result queue between the accumulators and the output port.
    localparam int RES_Q_DEPTH = 4;
    localparam int RES_Q_AW    = 2;
    localparam int RES_CNT_W   = 3;

    localparam logic [CNT_W-1:0]  MAX_BLOCK        = 17'd65536;
    localparam logic [HALF_W-1:0] HALF_SPACING_RST = 23'd2097152;
    localparam logic [LEN_W-1:0]  CODE_LENGTH_RST  = 11'd1023;
    localparam logic [CNT_W-1:0]  BLOCK_LENGTH_RST = 17'd4000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CARR_PHASE_INIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CARR_STEP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_PHASE_INIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SPACING    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH    = 3'd6;

    // Item kinds carried in tuser.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Values that a new integration block starts from.
    typedef struct packed {
        logic [31:0]      carr_init;
        logic [31:0]      carr_step;
        logic [PH_W-1:0]  code_e;
        logic [PH_W-1:0]  code_p;
        logic [PH_W-1:0]  code_l;
        logic [PH_W-1:0]  code_step;
        logic [PH_W-1:0]  period;
        logic [CNT_W-1:0] blk_len;
    } t_blk_cfg;

    // Per-sample lookups produced by the phase generators.
    typedef struct packed {
        logic [LEN_W-1:0] idx_e;
        logic [LEN_W-1:0] idx_p;
        logic [LEN_W-1:0] idx_l;
        logic [TIX_W-1:0] tix;
        logic             last;
    } t_tap;

    // round(16*cos(k*pi/8)), four fractional bits.
    function automatic logic signed [TAB_W-1:0] cos_lut(input logic [TIX_W-1:0] k);
        logic signed [TAB_W-1:0] v;
        case (k)
            4'd0:    v = 6'sd16;
            4'd1:    v = 6'sd15;
            4'd2:    v = 6'sd11;
            4'd3:    v = 6'sd6;
            4'd4:    v = 6'sd0;
            4'd5:    v = -6'sd6;
            4'd6:    v = -6'sd11;
            4'd7:    v = -6'sd15;
            4'd8:    v = -6'sd16;
            4'd9:    v = -6'sd15;
            4'd10:   v = -6'sd11;
            4'd11:   v = -6'sd6;
            4'd12:   v = 6'sd0;
            4'd13:   v = 6'sd6;
            4'd14:   v = 6'sd11;
            default: v = 6'sd15;
        endcase
        return v;
    endfunction

    // The sine table is the cosine table a quarter cycle later.
    function automatic logic signed [TAB_W-1:0] sin_lut(input logic [TIX_W-1:0] k);
        logic [TIX_W-1:0] j;
        j = k - 4'd4;
        return cos_lut(j);
    endfunction

    // (a + b) mod p for a, b already below p.
    function automatic logic [PH_W-1:0] wrap_add(input logic [PH_W-1:0] a,
                                                 input logic [PH_W-1:0] b,
                                                 input logic [PH_W-1:0] p);
        logic [PH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[PH_W-1:0];
    endfunction

endpackage

// ===== hdl/gepl_rem.sv =====
// Restoring remainder, one dividend bit per cycle.
module gepl_rem (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [gepl_pkg::REM_DIVIDEND_W-1:0] i_dividend,
    input  logic [gepl_pkg::LEN_W-1:0]          i_divisor,
    output logic                                o_busy,
    output logic [gepl_pkg::LEN_W-1:0]          o_rem
);
    localparam int DW     = gepl_pkg::REM_DIVIDEND_W;
    localparam int LW     = gepl_pkg::LEN_W;
    localparam int CNT_BW = $clog2(DW + 1);

    logic [CNT_BW-1:0] r_cnt;
    logic [DW-1:0]     r_shift;
    logic [LW-1:0]     r_rem;
    logic [LW-1:0]     r_div;
    logic [LW:0]       n_trial;

    always_comb begin
        n_trial = {r_rem, r_shift[DW-1]};
        if (n_trial >= {1'b0, r_div}) begin
            n_trial = n_trial - {1'b0, r_div};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_BW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_div   <= i_divisor;
            r_rem   <= '0;
        end else if (r_cnt != '0) begin
            r_shift <= {r_shift[DW-2:0], 1'b0};
            r_rem   <= n_trial[LW-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;

endmodule

// ===== hdl/gepl_cfg.sv =====
// Configuration registers and the setup that turns them into block start values.
module gepl_cfg #(
    parameter int CODE_DEPTH = gepl_pkg::CODE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gepl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gepl_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output gepl_pkg::t_blk_cfg               o_pend,
    output logic                             o_busy
);
    localparam int LW = gepl_pkg::LEN_W;
    localparam int FC = gepl_pkg::FRAC_CODE;
    localparam int PW = gepl_pkg::PH_W;
    localparam int CAP_INT = (CODE_DEPTH > 2047) ? 2047 : CODE_DEPTH;
    localparam logic [LW-1:0] LEN_CAP = LW'(CAP_INT);

    typedef enum logic [2:0] {
        ST_START,
        ST_DIV,
        ST_EARLY,
        ST_PROMPT,
        ST_LATE,
        ST_IDLE
    } t_state;

    t_state r_state;

    logic [31:0]                    r_carr_init;
    logic [31:0]                    r_carr_step;
    logic [31:0]                    r_code_init;
    logic [31:0]                    r_code_step;
    logic [gepl_pkg::HALF_W-1:0]    r_half;
    logic [LW-1:0]                  r_len;
    logic [gepl_pkg::CNT_W-1:0]     r_blk;

    logic [PW-1:0] r_dneg;
    logic [PW-1:0] r_code_e;
    logic [PW-1:0] r_code_p;
    logic [PW-1:0] r_code_l;

    logic [LW-1:0]               len_c;
    logic [gepl_pkg::CNT_W-1:0]  blk_c;
    logic                        d_int;
    logic [PW-1:0]               period;
    logic [PW-1:0]               half_d;
    logic [PW-1:0]               step_w;
    logic [PW-1:0]               init_w;
    logic                        rem_start;
    logic                        rem_step_busy;
    logic                        rem_init_busy;
    logic [LW-1:0]               rem_step;
    logic [LW-1:0]               rem_init;

    always_comb begin
        if (r_len == '0) begin
            len_c = LW'(1);
        end else if (r_len > LEN_CAP) begin
            len_c = LEN_CAP;
        end else begin
            len_c = r_len;
        end
        if (r_blk == '0) begin
            blk_c = gepl_pkg::CNT_W'(1);
        end else if (r_blk > gepl_pkg::MAX_BLOCK) begin
            blk_c = gepl_pkg::MAX_BLOCK;
        end else begin
            blk_c = r_blk;
        end
    end

    // The spacing has at most one whole chip, which vanishes in a one-chip period.
    assign d_int  = (len_c == LW'(1)) ? 1'b0 : r_half[FC];
    assign period = {len_c, {FC{1'b0}}};
    assign half_d = {{(LW-1){1'b0}}, d_int, r_half[FC-1:0]};
    assign step_w = {rem_step, r_code_step[FC-1:0]};
    assign init_w = {rem_init, r_code_init[FC-1:0]};

    assign rem_start = (r_state == ST_START);

    gepl_rem u_rem_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_code_step[31:FC]),
        .i_divisor  (len_c),
        .o_busy     (rem_step_busy),
        .o_rem      (rem_step)
    );

    gepl_rem u_rem_init (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_code_init[31:FC]),
        .i_divisor  (len_c),
        .o_busy     (rem_init_busy),
        .o_rem      (rem_init)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_START;
            r_carr_init <= '0;
            r_carr_step <= '0;
            r_code_init <= '0;
            r_code_step <= '0;
            r_half      <= gepl_pkg::HALF_SPACING_RST;
            r_len       <= gepl_pkg::CODE_LENGTH_RST;
            r_blk       <= gepl_pkg::BLOCK_LENGTH_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    gepl_pkg::REG_CARR_PHASE_INIT: r_carr_init <= i_cfg_wdata;
                    gepl_pkg::REG_CARR_STEP:       r_carr_step <= i_cfg_wdata;
                    gepl_pkg::REG_CODE_PHASE_INIT: r_code_init <= i_cfg_wdata;
                    gepl_pkg::REG_CODE_STEP:       r_code_step <= i_cfg_wdata;
                    gepl_pkg::REG_HALF_SPACING:
                        r_half <= i_cfg_wdata[gepl_pkg::HALF_W-1:0];
                    gepl_pkg::REG_CODE_LENGTH:     r_len <= i_cfg_wdata[LW-1:0];
                    gepl_pkg::REG_BLOCK_LENGTH:
                        r_blk <= i_cfg_wdata[gepl_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cfg_we) begin
                r_state <= ST_START;
            end else begin
                unique case (r_state)
                    ST_START:  r_state <= ST_DIV;
                    ST_DIV: begin
                        if (!rem_step_busy && !rem_init_busy) begin
                            r_state <= ST_EARLY;
                        end
                    end
                    ST_EARLY:  r_state <= ST_PROMPT;
                    ST_PROMPT: r_state <= ST_LATE;
                    ST_LATE:   r_state <= ST_IDLE;
                    ST_IDLE:   r_state <= ST_IDLE;
                    default:   r_state <= ST_START;
                endcase
            end
        end
    end

    // Start phases: early = init - d, prompt and late one spacing apart each.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_START) begin
            r_dneg <= period - half_d;
        end
        if (r_state == ST_EARLY) begin
            r_code_e <= gepl_pkg::wrap_add(init_w, r_dneg, period);
        end
        if (r_state == ST_PROMPT) begin
            r_code_p <= gepl_pkg::wrap_add(r_code_e, half_d, period);
        end
        if (r_state == ST_LATE) begin
            r_code_l <= gepl_pkg::wrap_add(r_code_p, half_d, period);
        end
    end

    always_comb begin
        o_pend.carr_init = r_carr_init;
        o_pend.carr_step = r_carr_step;
        o_pend.code_e    = r_code_e;
        o_pend.code_p    = r_code_p;
        o_pend.code_l    = r_code_l;
        o_pend.code_step = step_w;
        o_pend.period    = period;
        o_pend.blk_len   = blk_c;
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== hdl/gepl_nco.sv =====
// Carrier and code phase generators plus the sample counter of a block.
module gepl_nco (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  gepl_pkg::t_blk_cfg  i_pend,
    output gepl_pkg::t_tap      o_tap
);
    localparam int PW = gepl_pkg::PH_W;
    localparam int FC = gepl_pkg::FRAC_CODE;
    localparam int CW = gepl_pkg::CNT_W;

    logic [31:0]   r_carr;
    logic [PW-1:0] r_e;
    logic [PW-1:0] r_p;
    logic [PW-1:0] r_l;
    logic [CW-1:0] r_sc;
    logic [PW-1:0] r_step;
    logic [PW-1:0] r_period;
    logic [31:0]   r_cstep;
    logic [CW-1:0] r_len;

    logic          first;
    logic [31:0]   cur_carr;
    logic [PW-1:0] cur_e;
    logic [PW-1:0] cur_p;
    logic [PW-1:0] cur_l;
    logic [PW-1:0] cur_step;
    logic [PW-1:0] cur_period;
    logic [31:0]   cur_cstep;
    logic [CW-1:0] cur_len;
    logic [CW-1:0] sc_inc;
    logic          last;

    // The first sample of a block starts from the set-up values.
    assign first      = (r_sc == '0);
    assign cur_carr   = first ? i_pend.carr_init : r_carr;
    assign cur_e      = first ? i_pend.code_e    : r_e;
    assign cur_p      = first ? i_pend.code_p    : r_p;
    assign cur_l      = first ? i_pend.code_l    : r_l;
    assign cur_step   = first ? i_pend.code_step : r_step;
    assign cur_period = first ? i_pend.period    : r_period;
    assign cur_cstep  = first ? i_pend.carr_step : r_cstep;
    assign cur_len    = first ? i_pend.blk_len   : r_len;

    assign sc_inc = r_sc + 1'b1;
    assign last   = (sc_inc == cur_len);

    always_comb begin
        o_tap.idx_e = cur_e[PW-1:FC];
        o_tap.idx_p = cur_p[PW-1:FC];
        o_tap.idx_l = cur_l[PW-1:FC];
        // Nearest sixteenth of a cycle.
        o_tap.tix   = cur_carr[31:28] + {3'b000, cur_carr[27]};
        o_tap.last  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc <= '0;
        end else if (i_take) begin
            r_sc <= last ? '0 : sc_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_carr   <= cur_carr + cur_cstep;
            r_e      <= gepl_pkg::wrap_add(cur_e, cur_step, cur_period);
            r_p      <= gepl_pkg::wrap_add(cur_p, cur_step, cur_period);
            r_l      <= gepl_pkg::wrap_add(cur_l, cur_step, cur_period);
            r_step   <= cur_step;
            r_period <= cur_period;
            r_cstep  <= cur_cstep;
            r_len    <= cur_len;
        end
    end

endmodule

// ===== hdl/gepl_chip_mem.sv =====
// Code chip table, kept in three copies so that early, prompt and late
// chips are read in the same cycle.
module gepl_chip_mem #(
    parameter int CODE_DEPTH = gepl_pkg::CODE_DEPTH_DEF,
    localparam int AW = $clog2(CODE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_e,
    input  logic [AW-1:0] i_raddr_p,
    input  logic [AW-1:0] i_raddr_l,
    output logic [2:0]    o_chips
);
    logic r_mem_e [CODE_DEPTH];
    logic r_mem_p [CODE_DEPTH];
    logic r_mem_l [CODE_DEPTH];
    logic [2:0] r_chips;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_e[i_waddr] <= i_wdata;
            r_mem_p[i_waddr] <= i_wdata;
            r_mem_l[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_chips <= {r_mem_l[i_raddr_l], r_mem_p[i_raddr_p], r_mem_e[i_raddr_e]};
        end
    end

    assign o_chips = r_chips;

endmodule

// ===== hdl/gepl_accum.sv =====
// Carrier wipe-off, code multiply and the six integrate-and-dump sums.
module gepl_accum #(
    parameter int SAMPLE_BITS = gepl_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_BITS    = gepl_pkg::ACC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  logic [gepl_pkg::TIX_W-1:0]      i_tix,
    input  logic                            i_last,
    input  logic [2:0]                      i_chips,
    output logic                            o_res_valid,
    output logic [gepl_pkg::RES_W-1:0]      o_res
);
    localparam int PW = SAMPLE_BITS + 5;
    localparam int NS = gepl_pkg::N_SUMS;
    localparam int OW = gepl_pkg::OUT_W;

    // Stage 1: sample and table index, chips arrive from the table alongside.
    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic [gepl_pkg::TIX_W-1:0]    r_s1_tix;
    logic                          r_s1_last;

    // Stage 2: wiped-off I and Q.
    logic                 r_s2_valid;
    logic signed [PW-1:0] r_s2_ci;
    logic signed [PW-1:0] r_s2_cq;
    logic [2:0]           r_s2_chips;
    logic                 r_s2_last;

    // Stage 3: the sums.
    logic signed [ACC_BITS-1:0] r_acc [NS];
    logic signed [ACC_BITS-1:0] n_acc [NS];
    logic                       r_res_valid;
    logic [gepl_pkg::RES_W-1:0] r_res;

    logic signed [PW-1:0] s_ext;
    logic signed [PW-1:0] sin_ext;
    logic signed [PW-1:0] cos_ext;
    logic signed [PW-1:0] ci;
    logic signed [PW-1:0] cq;

    assign s_ext   = PW'(r_s1_sample);
    assign sin_ext = PW'(gepl_pkg::sin_lut(r_s1_tix));
    assign cos_ext = PW'(gepl_pkg::cos_lut(r_s1_tix));
    assign ci      = s_ext * sin_ext;
    assign cq      = s_ext * cos_ext;

    // Sums in order: I early, Q early, I prompt, Q prompt, I late, Q late.
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            logic signed [ACC_BITS-1:0] term;
            term = ((k & 1) == 0) ? ACC_BITS'(r_s2_ci) : ACC_BITS'(r_s2_cq);
            if (r_s2_chips[k >> 1]) begin
                n_acc[k] = r_acc[k] + term;
            end else begin
                n_acc[k] = r_acc[k] - term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            for (int k = 0; k < NS; k++) begin
                r_acc[k] <= '0;
            end
        end else begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_res_valid <= r_s2_valid && r_s2_last;
            if (r_s2_valid) begin
                for (int k = 0; k < NS; k++) begin
                    r_acc[k] <= r_s2_last ? '0 : n_acc[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_s1_sample <= i_sample;
            r_s1_tix    <= i_tix;
            r_s1_last   <= i_last;
        end
        if (r_s1_valid) begin
            r_s2_ci    <= ci;
            r_s2_cq    <= cq;
            r_s2_chips <= i_chips;
            r_s2_last  <= r_s1_last;
        end
        if (r_s2_valid && r_s2_last) begin
            for (int k = 0; k < NS; k++) begin
                r_res[k*OW +: OW] <= OW'(n_acc[k]);
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== hdl/gnss_early_prompt_late_correlator.sv =====
// GNSS early/prompt/late correlator channel. One item enters per clock on the
// slave stream: tuser 0 marks an IF sample, tuser 1 a code chip load that writes
// one entry of the chip table. Each sample is wiped off with a 16-step sine and
// cosine carrier, multiplied by the early, prompt and late code chips and added
// into six sums; after block_length samples the sums leave as one item on the
// master stream once the block's last sample has passed the sample, wipe-off
// and sum registers and the result queue, and the next block restarts its
// phases from the registers. The pipeline takes one item per clock and only
// pauses in two cases: while four results are owed to the master side (the
// result queue is four deep), and after reset or after any register write,
// while two bit-serial remainder units fold the code phase and code step into
// the code period and the three start phases are set up. Writes take effect at
// the next block. Chip entries must be loaded before a sample reads them.
`include "gnss_early_prompt_late_correlator_assert.svh"

module gnss_early_prompt_late_correlator #(
    parameter int CODE_DEPTH  = gepl_pkg::CODE_DEPTH_DEF,
    parameter int SAMPLE_BITS = gepl_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_BITS    = gepl_pkg::ACC_BITS_DEF,
    localparam int IN_W = ((SAMPLE_BITS + gepl_pkg::CHIP_IDX_W + 1 + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Slave stream: samples and chip loads.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // From bit 0 up: sample, chip_index, chip_value, zero fill.
    input  logic [IN_W-1:0]                  s_axis_tdata,
    // opcode: 0 sample, 1 chip load.
    input  logic                             s_axis_tuser,
    // Master stream: one item per finished block.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // From bit 0 up: i_early, q_early, i_prompt, q_prompt, i_late, q_late.
    output logic [gepl_pkg::RES_W-1:0]       m_axis_tdata,
    // Register write port.
    input  logic                             i_cfg_we,
    input  logic [gepl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gepl_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    localparam int AW = $clog2(CODE_DEPTH);
    localparam int LW = gepl_pkg::LEN_W;
    localparam int WW = (AW > LW) ? AW : LW;
    localparam int QD = gepl_pkg::RES_Q_DEPTH;
    localparam int QA = gepl_pkg::RES_Q_AW;
    localparam int CW = gepl_pkg::RES_CNT_W;
    localparam logic [CW-1:0] Q_FULL = CW'(QD);

    // Input fields.
    logic signed [SAMPLE_BITS-1:0]      in_sample;
    logic [gepl_pkg::CHIP_IDX_W-1:0]    in_idx;
    logic                               in_chip;

    assign in_sample = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
    assign in_idx    = s_axis_tdata[SAMPLE_BITS +: gepl_pkg::CHIP_IDX_W];
    assign in_chip   = s_axis_tdata[SAMPLE_BITS + gepl_pkg::CHIP_IDX_W];

    logic take;
    logic take_sample;
    logic take_load;
    logic load_we;
    logic cfg_busy;
    logic out_take;
    logic res_valid;
    logic [gepl_pkg::RES_W-1:0] res;
    logic [2:0] chips;

    gepl_pkg::t_blk_cfg pend;
    gepl_pkg::t_tap     tap;

    logic [WW-1:0] waddr_ext;
    logic [WW-1:0] ra_e_ext;
    logic [WW-1:0] ra_p_ext;
    logic [WW-1:0] ra_l_ext;

    // Results accepted but not yet delivered: in the pipeline or in the queue.
    logic [CW-1:0] r_pend;
    logic [gepl_pkg::RES_W-1:0] r_q [QD];
    logic [QA-1:0] r_wp;
    logic [QA-1:0] r_rp;
    logic [CW-1:0] r_qcnt;

    // Holding back only when every queue slot is spoken for keeps the queue
    // from overflowing without ever stalling the pipeline itself.
    assign s_axis_tready = !cfg_busy && (r_pend < Q_FULL);
    assign take          = s_axis_tvalid && s_axis_tready;
    assign take_sample   = take && (s_axis_tuser == gepl_pkg::OP_SAMPLE);
    assign take_load     = take && (s_axis_tuser == gepl_pkg::OP_LOAD);
    assign load_we       = take_load && (32'(in_idx) < 32'(CODE_DEPTH));

    assign waddr_ext = WW'(in_idx);
    assign ra_e_ext  = WW'(tap.idx_e);
    assign ra_p_ext  = WW'(tap.idx_p);
    assign ra_l_ext  = WW'(tap.idx_l);

    gepl_cfg #(
        .CODE_DEPTH (CODE_DEPTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pend      (pend),
        .o_busy      (cfg_busy)
    );

    gepl_nco u_nco (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take_sample),
        .i_pend  (pend),
        .o_tap   (tap)
    );

    gepl_chip_mem #(
        .CODE_DEPTH (CODE_DEPTH)
    ) u_chip_mem (
        .i_clk     (i_clk),
        .i_we      (load_we),
        .i_waddr   (waddr_ext[AW-1:0]),
        .i_wdata   (in_chip),
        .i_re      (take_sample),
        .i_raddr_e (ra_e_ext[AW-1:0]),
        .i_raddr_p (ra_p_ext[AW-1:0]),
        .i_raddr_l (ra_l_ext[AW-1:0]),
        .o_chips   (chips)
    );

    gepl_accum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (take_sample),
        .i_sample    (in_sample),
        .i_tix       (tap.tix),
        .i_last      (tap.last),
        .i_chips     (chips),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign out_take = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
        end else begin
            case ({take_sample && tap.last, out_take})
                2'b10:   r_pend <= r_pend + 1'b1;
                2'b01:   r_pend <= r_pend - 1'b1;
                default: r_pend <= r_pend;
            endcase
            case ({res_valid, out_take})
                2'b10:   r_qcnt <= r_qcnt + 1'b1;
                2'b01:   r_qcnt <= r_qcnt - 1'b1;
                default: r_qcnt <= r_qcnt;
            endcase
            if (res_valid) begin
                r_wp <= r_wp + 1'b1;
            end
            if (out_take) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_q[r_wp] <= res;
        end
    end

    assign m_axis_tvalid = (r_qcnt != '0);
    assign m_axis_tdata  = r_q[r_rp];

    `GEPL_ASSERT_ALWAYS(a_pend_bound, i_clk, i_rst_n, r_pend <= Q_FULL, "result credit overrun")
    `GEPL_ASSERT_ALWAYS(a_queue_in_credit, i_clk, i_rst_n, r_qcnt <= r_pend, "queue holds uncounted result")
    `GEPL_ASSERT_IMPLY(a_queue_room, i_clk, i_rst_n, res_valid, r_qcnt < Q_FULL, "result queue overflow")
    `GEPL_ASSERT_IMPLY(a_result_owed, i_clk, i_rst_n, res_valid, r_pend != '0, "result without credit")

endmodule
